/* rtl/core/assert_macros.svh */
// Assertion macros shared by the point projection RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ppp_pkg.sv */
// Types, widths and codes of the pinhole point projection pipeline.
// No dependencies; used by every other RTL file but assert_macros.svh.
package ppp_pkg;

  localparam int PW     = 20;        // point coordinate, Q16.4
  localparam int RW     = 20;        // rotation coefficient, Q2.18
  localparam int TW     = 21;        // translation, Q17.4
  localparam int KW     = 21;        // intrinsic coefficient, Q13.8
  localparam int TSH    = 18;        // align translation to 22 fraction bits
  localparam int CW     = 43;        // camera coordinate
  localparam int CLW    = 22;        // low slice of a camera coordinate
  localparam int HW     = 64;        // homogeneous coordinate
  localparam int MW     = 63;        // magnitude of a homogeneous coordinate
  localparam int FRAC   = 5;         // quotient fraction bits: those of the output plus one round bit
  localparam int QW     = 25;        // quotient bits kept
  localparam int QINT   = QW - FRAC; // integer quotient limit, as a power of two
  localparam int DW     = MW + QW;   // divider remainder width
  localparam int OW     = 24;        // pixel coordinate, Q20.4
  localparam int RROW_W = 3 * RW;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 63;

  localparam logic [QW:0] MAG_POS_MAX = (QW+1)'(2**(OW-1) - 1);
  localparam logic [QW:0] MAG_NEG_MAX = (QW+1)'(2**(OW-1));

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROT_A  = 3'd0,
    REG_ROT_B  = 3'd1,
    REG_ROT_C  = 3'd2,
    REG_OFFSET = 3'd3,
    REG_K_A    = 3'd4,
    REG_K_B    = 3'd5,
    REG_K_C    = 3'd6
  } cfg_reg_e;

  typedef logic signed [PW-1:0] coord_t;
  typedef logic signed [OW-1:0] pix_t;
  typedef logic signed [CW-1:0] cam_t;
  typedef logic signed [HW-1:0] hom_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    cam_t x;
    cam_t y;
    cam_t z;
  } cam_vec_t;

  typedef struct packed {
    hom_t h0;
    hom_t h1;
    hom_t h2;
  } hom_vec_t;

  typedef struct packed {
    pix_t    u;
    pix_t    v;
    status_e status;
  } result_t;

endpackage

/* rtl/core/ppp_if.sv */
// Stream and configuration interfaces of the point projection block.
// Depends on ppp_pkg.
interface ppp_point_if;
  logic            valid;
  logic            ready;
  ppp_pkg::coord_t point_x;
  ppp_pkg::coord_t point_y;
  ppp_pkg::coord_t point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_result_if;
  logic                     valid;
  logic                     ready;
  ppp_pkg::pix_t            image_u;
  ppp_pkg::pix_t            image_v;
  logic [1:0]               status;

  modport source (output valid, image_u, image_v, status, input ready);
  modport sink   (input valid, image_u, image_v, status, output ready);
endinterface

interface ppp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ppp_pkg::CFG_AW-1:0]   index;
  logic [ppp_pkg::CFG_DW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ppp_cam.sv */
// Camera transform c = R*p + t: a multiply stage and an add stage.
// Depends on ppp_pkg.
module ppp_cam (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ppp_pkg::point_t                 in_point_i,
  input  logic [ppp_pkg::RROW_W-1:0]      rot_i [3],
  input  logic [ppp_pkg::CFG_DW-1:0]      off_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ppp_pkg::cam_vec_t               out_cam_o
);
  import ppp_pkg::*;

  localparam int NS = 2;
  localparam int PRW = RW + PW;

  logic [NS-1:0]          vld_q;
  logic [NS-1:0]          en;
  logic signed [PRW-1:0]  prod_d [3][3];
  logic signed [PRW-1:0]  prod_q [3][3];
  cam_t                   cam_d [3];
  cam_t                   cam_q [3];
  coord_t                 pt [3];

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready_i || !(&vld_q[NS-1:k]);
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
    end
  end

  assign pt[0] = in_point_i.x;
  assign pt[1] = in_point_i.y;
  assign pt[2] = in_point_i.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = $signed(rot_i[i][RW*j +: RW]) * pt[j];
      end
    end
  end

  // translation enters with 22 fraction bits, like the products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_d[i] = (CW'($signed(off_i[TW*i +: TW])) <<< TSH) + CW'(prod_q[i][0])
               + CW'(prod_q[i][1]) + CW'(prod_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) prod_q <= prod_d;
    if (en[1]) cam_q  <= cam_d;
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_cam_o   = '{x: cam_q[0], y: cam_q[1], z: cam_q[2]};

endmodule

/* rtl/core/ppp_hom.sv */
// Intrinsic transform h = K*c, each 21x43 product split in two slices.
// Depends on ppp_pkg; three register stages.
module ppp_hom (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ppp_pkg::cam_vec_t               in_cam_i,
  input  logic [ppp_pkg::CFG_DW-1:0]      k_i [3],
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ppp_pkg::hom_vec_t               out_hom_o
);
  import ppp_pkg::*;

  localparam int NS  = 3;
  localparam int CHW = CW - CLW;
  localparam int LPW = KW + CLW + 1;
  localparam int HPW = KW + CHW;
  localparam int LSW = LPW + 2;
  localparam int HSW = HPW + 2;

  logic [NS-1:0]          vld_q;
  logic [NS-1:0]          en;
  cam_t                   c [3];
  logic signed [LPW-1:0]  plo_d [3][3];
  logic signed [LPW-1:0]  plo_q [3][3];
  logic signed [HPW-1:0]  phi_d [3][3];
  logic signed [HPW-1:0]  phi_q [3][3];
  logic signed [LSW-1:0]  slo_d [3];
  logic signed [LSW-1:0]  slo_q [3];
  logic signed [HSW-1:0]  shi_d [3];
  logic signed [HSW-1:0]  shi_q [3];
  hom_t                   h_d [3];
  hom_t                   h_q [3];

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready_i || !(&vld_q[NS-1:k]);
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign c[0] = in_cam_i.x;
  assign c[1] = in_cam_i.y;
  assign c[2] = in_cam_i.z;

  // low slice is unsigned, high slice carries the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        plo_d[i][j] = $signed(k_i[i][KW*j +: KW]) * $signed({1'b0, c[j][CLW-1:0]});
        phi_d[i][j] = $signed(k_i[i][KW*j +: KW]) * $signed(c[j][CW-1:CLW]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slo_d[i] = LSW'(plo_q[i][0]) + LSW'(plo_q[i][1]) + LSW'(plo_q[i][2]);
      shi_d[i] = HSW'(phi_q[i][0]) + HSW'(phi_q[i][1]) + HSW'(phi_q[i][2]);
      h_d[i]   = (HW'(shi_q[i]) <<< CLW) + HW'(slo_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (en[1]) begin
      slo_q <= slo_d;
      shi_q <= shi_d;
    end
    if (en[2]) h_q <= h_d;
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_hom_o   = '{h0: h_q[0], h1: h_q[1], h2: h_q[2]};

endmodule

/* rtl/core/ppp_div.sv */
// Two-lane pipelined restoring divider: u = h0*16/h2, v = h1*16/h2, rounded
// and saturated. One quotient bit per stage. Depends on ppp_pkg.
module ppp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ppp_pkg::hom_vec_t   in_hom_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ppp_pkg::result_t    out_res_o
);
  import ppp_pkg::*;

  // prep, overflow check, QW bit stages, output stage
  localparam int NS = QW + 3;

  typedef struct packed {
    logic [DW-1:0] ra;
    logic [DW-1:0] rb;
    logic [MW-1:0] b;
    logic [QW-1:0] qa;
    logic [QW-1:0] qb;
    logic          na;
    logic          nb;
    logic          zero;
    logic          oa;
    logic          ob;
  } div_t;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;
  div_t          st_d [NS-1];
  div_t          st_q [NS-1];
  result_t       res_d;
  result_t       res_q;
  div_t          s0;
  div_t          s1;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready_i || !(&vld_q[NS-1:k]);
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  function automatic logic [MW-1:0] mag(hom_t h);
    return h[HW-1] ? MW'(-h) : MW'(h);
  endfunction

  always_comb begin
    s0      = '0;
    s0.ra   = DW'(mag(in_hom_i.h0));
    s0.rb   = DW'(mag(in_hom_i.h1));
    s0.b    = mag(in_hom_i.h2);
    s0.na   = in_hom_i.h0[HW-1] ^ in_hom_i.h2[HW-1];
    s0.nb   = in_hom_i.h1[HW-1] ^ in_hom_i.h2[HW-1];
    s0.zero = (in_hom_i.h2 == '0);
  end
  assign st_d[0] = s0;

  // integer quotient of 2^QINT or more saturates anyway
  always_comb begin
    s1    = st_q[0];
    s1.oa = st_q[0].ra >= (DW'(st_q[0].b) << QINT);
    s1.ob = st_q[0].rb >= (DW'(st_q[0].b) << QINT);
    s1.ra = st_q[0].ra << FRAC;
    s1.rb = st_q[0].rb << FRAC;
  end
  assign st_d[1] = s1;

  for (genvar k = 2; k < NS-1; k++) begin : g_bit
    localparam int Bit = QW + 1 - k;
    div_t          nxt;
    logic [DW-1:0] bsh;

    assign bsh = DW'(st_q[k-1].b) << Bit;

    always_comb begin
      nxt = st_q[k-1];
      if (st_q[k-1].ra >= bsh) begin
        nxt.ra     = st_q[k-1].ra - bsh;
        nxt.qa[Bit] = 1'b1;
      end
      if (st_q[k-1].rb >= bsh) begin
        nxt.rb     = st_q[k-1].rb - bsh;
        nxt.qb[Bit] = 1'b1;
      end
    end
    assign st_d[k] = nxt;
  end

  // {saturated, value}: round half away from zero on the magnitude, then clamp
  function automatic logic [OW:0] finish(logic [QW-1:0] q, logic neg, logic ovf);
    logic [QW:0] m;
    logic [OW:0] r;
    m = ({1'b0, q} + (QW+1)'(1)) >> 1;
    if (neg) begin
      if (ovf || m > MAG_NEG_MAX) r = {1'b1, OW'(MAG_NEG_MAX)};
      else                        r = {1'b0, -OW'(m)};
    end else begin
      if (ovf || m > MAG_POS_MAX) r = {1'b1, OW'(MAG_POS_MAX)};
      else                        r = {1'b0, OW'(m)};
    end
    return r;
  endfunction

  always_comb begin
    logic [OW:0] fu;
    logic [OW:0] fv;
    fu = finish(st_q[NS-2].qa, st_q[NS-2].na, st_q[NS-2].oa);
    fv = finish(st_q[NS-2].qb, st_q[NS-2].nb, st_q[NS-2].ob);
    if (st_q[NS-2].zero) begin
      res_d = '{u: '0, v: '0, status: ST_ZERO};
    end else begin
      res_d.u      = fu[OW-1:0];
      res_d.v      = fv[OW-1:0];
      res_d.status = (fu[OW] || fv[OW]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS-1; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
    if (en[NS-1]) res_q <= res_d;
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_res_o   = res_q;

endmodule

/* rtl/core/pinhole_point_projection_unit.sv */
// Pinhole point projection: one point in, one pixel (u, v, status) out.
// A new point is accepted every clock cycle unless the full pipeline is
// stalled; each passes the camera, intrinsic and divider stages, and the
// divider resolves one quotient bit per stage. Back-pressure stalls only the
// full part of the pipeline, so bubbles close up under a stalled output. The
// matrices are written through the configuration channel, always ready; the
// user must write them only while no point is in flight, which the block does
// not enforce. Depends on ppp_pkg, ppp_if, ppp_cam, ppp_hom, ppp_div.
`include "assert_macros.svh"

module pinhole_point_projection_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ppp_point_if.sink     point_i,
  ppp_cfg_if.sink       cfg_i,
  ppp_result_if.source  result_o
);
  import ppp_pkg::*;

  logic [RROW_W-1:0] rot_q [3];
  logic [CFG_DW-1:0] off_q;
  logic [CFG_DW-1:0] k_q [3];

  logic      cam_valid;
  logic      cam_ready;
  cam_vec_t  cam_vec;
  logic      hom_valid;
  logic      hom_ready;
  hom_vec_t  hom_vec;
  point_t    pt;
  result_t   res;
  logic      cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '{default: '0};
      off_q <= '0;
      k_q   <= '{default: '0};
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ROT_A:  rot_q[0] <= cfg_i.data[RROW_W-1:0];
        REG_ROT_B:  rot_q[1] <= cfg_i.data[RROW_W-1:0];
        REG_ROT_C:  rot_q[2] <= cfg_i.data[RROW_W-1:0];
        REG_OFFSET: off_q    <= cfg_i.data;
        REG_K_A:    k_q[0]   <= cfg_i.data;
        REG_K_B:    k_q[1]   <= cfg_i.data;
        REG_K_C:    k_q[2]   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pt = '{x: point_i.point_x, y: point_i.point_y, z: point_i.point_z};

  ppp_cam u_cam (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .in_point_i  (pt),
    .rot_i       (rot_q),
    .off_i       (off_q),
    .out_valid_o (cam_valid),
    .out_ready_i (cam_ready),
    .out_cam_o   (cam_vec)
  );

  ppp_hom u_hom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cam_valid),
    .in_ready_o  (cam_ready),
    .in_cam_i    (cam_vec),
    .k_i         (k_q),
    .out_valid_o (hom_valid),
    .out_ready_i (hom_ready),
    .out_hom_o   (hom_vec)
  );

  ppp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hom_valid),
    .in_ready_o  (hom_ready),
    .in_hom_i    (hom_vec),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_res_o   (res)
  );

  assign result_o.image_u = res.u;
  assign result_o.image_v = res.v;
  assign result_o.status  = res.status;

  `PPP_ASSERT_IMP(a_zero_depth, result_o.valid && res.status == ST_ZERO,
                  res.u == '0 && res.v == '0, "zero depth with nonzero pixel")
  `PPP_ASSERT_IMP(a_sat_bound, result_o.valid && res.status == ST_SAT,
                  res.u == pix_t'(MAG_POS_MAX) || res.u == -pix_t'(MAG_NEG_MAX) ||
                  res.v == pix_t'(MAG_POS_MAX) || res.v == -pix_t'(MAG_NEG_MAX),
                  "saturated status without a clamped coordinate")
  `PPP_ASSERT_IMP(a_full_stall, !point_i.ready,
                  result_o.valid && !result_o.ready, "input stalled with a bubble in the pipe")
  `PPP_ASSERT_NXT(a_cfg_rot, cfg_we && cfg_i.index == REG_ROT_A,
                  rot_q[0] == $past(cfg_i.data[RROW_W-1:0]), "rotation row write lost")

endmodule

/* tb/pinhole_point_projection_unit_tb.sv */
// Self-checking testbench of the pinhole point projection unit.
// Drives points and matrix writes, predicts each pixel and compares it field by field.
// Depends on ppp_pkg, ppp_if and the unit's RTL.
module pinhole_point_projection_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic signed [23:0] u;
    logic signed [23:0] v;
    logic [1:0]         st;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  ppp_point_if  pt_if ();
  ppp_cfg_if    cfg_if ();
  ppp_result_if res_if ();

  pinhole_point_projection_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pt_if.sink),
    .cfg_i    (cfg_if.sink),
    .result_o (res_if.source)
  );

  logic [62:0] cam_regs [7];
  pixel_t      pixel_q [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          stall_mode = 0;

  initial begin
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    foreach (cam_regs[i]) cam_regs[i] = '0;
  end

  function automatic longint sx(logic [62:0] r, int j, int w);
    logic [62:0] s;
    longint      x;
    s = r >> (w * j);
    x = longint'(s) & ((64'sd1 <<< w) - 1);
    if (s[w-1]) x = x - (64'sd1 <<< w);
    return x;
  endfunction

  // |a|*16/|b| rounded half away from zero; 2^24 flags a too-large quotient
  function automatic logic [63:0] round_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] q, r;
    q = a / b;
    r = a % b;
    if (q >= 64'd1 << 20) return 64'd1 << 24;
    for (int k = 0; k < 5; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint pix_coord(longint n, longint d, inout bit sat);
    logic [63:0] m;
    m = round_div(n < 0 ? -n : n, d < 0 ? -d : d);
    if ((n < 0) != (d < 0)) begin
      if (m > 64'd8388608) begin
        sat = 1;
        return -64'sd8388608;
      end
      return -longint'(m);
    end
    if (m > 64'd8388607) begin
      sat = 1;
      return 64'sd8388607;
    end
    return longint'(m);
  endfunction

  function automatic pixel_t project_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
    longint p [3];
    longint c [3];
    longint h [3];
    pixel_t r;
    bit     sat;
    p[0] = longint'(signed'(px));
    p[1] = longint'(signed'(py));
    p[2] = longint'(signed'(pz));
    sat = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = sx(cam_regs[REG_OFFSET], i, 21) * (64'sd1 <<< 18);
      for (int j = 0; j < 3; j++) c[i] += sx(cam_regs[i], j, 20) * p[j];
    end
    for (int i = 0; i < 3; i++) begin
      h[i] = 0;
      for (int j = 0; j < 3; j++) h[i] += sx(cam_regs[REG_K_A + i], j, 21) * c[j];
    end
    r.u = '0;
    r.v = '0;
    r.st = ST_OK;
    if (h[2] == 0) r.st = ST_ZERO;
    else begin
      r.u = 24'(pix_coord(h[0], h[2], sat));
      r.v = 24'(pix_coord(h[1], h[2], sat));
      if (sat) r.st = ST_SAT;
    end
    return r;
  endfunction

  // receiver: stalls on alternating dense and open stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      res_if.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel beat u=%0d v=%0d", res_if.image_u,
                                       res_if.image_v);
      end else begin
        e = pixel_q.pop_front();
        if (res_if.image_u !== e.u || res_if.image_v !== e.v || res_if.status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp u=%0d v=%0d st=%0d got u=%0d v=%0d st=%0d",
                     e.u, e.v, e.st, res_if.image_u, res_if.image_v, res_if.status);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
    while (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (burst_left == 0) begin
        pt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    pt_if.valid <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.point_z <= pz;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    pixel_q.push_back(project_point(px, py, pz));
  endtask

  task automatic drain_pixels();
    pt_if.valid <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [62:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    cam_regs[idx] = (idx <= REG_ROT_C) ? {3'b0, val[59:0]} : val;
    @(posedge clk_i);
  endtask

  function automatic logic [62:0] pack3(int w, longint a, longint b, longint c);
    logic [62:0] m;
    m = (63'd1 << w) - 1;
    return (63'(a) & m) | ((63'(b) & m) << w) | ((63'(c) & m) << (2 * w));
  endfunction

  task automatic set_camera(longint f, longint cx, longint tz, bit rot90);
    write_reg(REG_ROT_A, rot90 ? pack3(20, 0, -262144, 0) : pack3(20, 262144, 0, 0));
    write_reg(REG_ROT_B, rot90 ? pack3(20, 262144, 0, 0) : pack3(20, 0, 262144, 0));
    write_reg(REG_ROT_C, pack3(20, 0, 0, 262144));
    write_reg(REG_OFFSET, pack3(21, 0, 0, tz));
    write_reg(REG_K_A, pack3(21, f, 0, cx));
    write_reg(REG_K_B, pack3(21, 0, f, cx));
    write_reg(REG_K_C, pack3(21, 0, 0, 256));
  endtask

  function automatic logic [19:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7ffff;
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic test_reset_matrices();
    // all-zero matrices give zero depth for every point
    send_point(20'h00000, 20'h00000, 20'h00000);
    send_point(20'h7ffff, 20'h80000, 20'h12345);
    drain_pixels();
  endtask

  task automatic test_directed();
    set_camera(1000 * 256, 640 * 256, 1000 * 16, 0);
    send_point(20'h00000, 20'h00000, 20'h00000);
    send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'h7ffff, 20'h80000, 20'h00010);
    send_point(20'h00100, 20'hfff00, 20'h80000);   // behind the camera
    send_point(20'h00000, 20'h00000, 20'hfc180);   // depth cancels the offset
    send_point(20'h0c350, 20'h0c350, 20'hfc190);   // tiny depth, saturates
    send_point(20'hf3cb0, 20'h0c350, 20'hfc190);
    send_point(20'h00003, 20'h00005, 20'h00001);
    drain_pixels();
    // extreme register values, including bits above the register widths
    write_reg(REG_ROT_A, 63'h7fff_ffff_ffff_ffff);
    write_reg(REG_ROT_B, pack3(20, -524288, -524288, -524288));
    write_reg(REG_ROT_C, pack3(20, 524287, 524287, 524287));
    write_reg(REG_OFFSET, pack3(21, -1048576, 1048575, -1048576));
    write_reg(REG_K_A, pack3(21, 1048575, -1048576, 1048575));
    write_reg(REG_K_B, 63'h7fff_ffff_ffff_ffff);
    write_reg(REG_K_C, pack3(21, -1048576, 1048575, 1));
    send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'h80000, 20'h7ffff, 20'h00000);
    send_point(20'h00000, 20'h00000, 20'h00000);
    drain_pixels();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 90 == 0) begin
        drain_pixels();
        if ($urandom_range(0, 2) == 0)
          foreach (cam_regs[i]) write_reg(cfg_reg_e'(i), 63'({$urandom, $urandom}));
        else
          set_camera($urandom_range(1, 1048575), $urandom_range(0, 1048575),
                     $urandom_range(0, 1048575), $urandom_range(0, 1) == 1);
      end
      send_point(rnd_coord(), rnd_coord(), rnd_coord());
    end
    drain_pixels();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrices();
    test_directed();
    test_random(540);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_if.sv
rtl/core/ppp_cam.sv
rtl/core/ppp_hom.sv
rtl/core/ppp_div.sv
rtl/core/pinhole_point_projection_unit.sv
tb/pinhole_point_projection_unit_tb.sv
